// ===== hdl/configurable_crc_engine_unit_assert.svh =====
// Assertion macros for the CRC engine.
`ifndef CONFIGURABLE_CRC_ENGINE_UNIT_ASSERT_SVH
`define CONFIGURABLE_CRC_ENGINE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// Checked on every rising edge outside reset.
`define CCRC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Checked on every rising edge, reset included.
`define CCRC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define CCRC_ASSERT(lbl, prop, msg)
`define CCRC_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== hdl/ccrc_pkg.sv =====
// Types, register indexes and constants shared by the CRC engine.
package ccrc_pkg;

  typedef enum logic [1:0] {
    WM_7  = 2'd0,
    WM_8  = 2'd1,
    WM_16 = 2'd2,
    WM_32 = 2'd3
  } width_mode_e;

  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] REG_WIDTH_MODE = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_POLYNOMIAL = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_INIT_VALUE = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_REFLECTED  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_XOR_OUT    = 3'd4;

  localparam logic [31:0] RST_POLYNOMIAL = 32'h04C1_1DB7;
  localparam logic [31:0] RST_INIT_VALUE = 32'hFFFF_FFFF;
  localparam logic [31:0] RST_XOR_OUT    = 32'hFFFF_FFFF;

  typedef struct packed {
    width_mode_e width_mode;
    logic [31:0] polynomial;
    logic [31:0] init_value;
    logic        reflected;
    logic [31:0] xor_out;
  } cfg_t;

  // Mask of the CRC bits for a width mode.
  function automatic logic [31:0] width_mask(width_mode_e mode);
    logic [31:0] m;
    case (mode)
      WM_7:    m = 32'h0000_007F;
      WM_8:    m = 32'h0000_00FF;
      WM_16:   m = 32'h0000_FFFF;
      default: m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

endpackage

// ===== hdl/ccrc_regs.sv =====
// Configuration register file of the CRC engine.
module ccrc_regs import ccrc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_en_i,
  input  logic [CfgIdxW-1:0] wr_index_i,
  input  logic [31:0]        wr_data_i,
  output cfg_t               cfg_o
);

  cfg_t cfg_q;
  cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (wr_index_i)
        REG_WIDTH_MODE: cfg_d.width_mode = width_mode_e'(wr_data_i[1:0]);
        REG_POLYNOMIAL: cfg_d.polynomial = wr_data_i;
        REG_INIT_VALUE: cfg_d.init_value = wr_data_i;
        REG_REFLECTED:  cfg_d.reflected  = wr_data_i[0];
        REG_XOR_OUT:    cfg_d.xor_out    = wr_data_i;
        default: ;  // unmapped index: drop the write
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width_mode <= WM_32;
      cfg_q.polynomial <= RST_POLYNOMIAL;
      cfg_q.init_value <= RST_INIT_VALUE;
      cfg_q.reflected  <= 1'b1;
      cfg_q.xor_out    <= RST_XOR_OUT;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hdl/ccrc_core.sv =====
// Byte-wide CRC update: eight XOR-shift steps and the final result.
module ccrc_core import ccrc_pkg::*; (
  input  cfg_t        cfg_i,
  input  logic [31:0] crc_i,
  input  logic        in_msg_i,
  input  logic [7:0]  data_byte_i,
  output logic [31:0] crc_next_o,
  output logic [31:0] result_o
);

  function automatic logic [31:0] rev32(logic [31:0] v);
    logic [31:0] r;
    for (int i = 0; i < 32; i++) begin
      r[i] = v[31-i];
    end
    return r;
  endfunction

  logic [31:0] wmask;
  logic [31:0] poly_n;
  logic [31:0] poly_rev;
  logic [31:0] poly_msb;
  logic [31:0] emask;
  logic [4:0]  top_idx;
  logic [4:0]  byte_sh;
  logic        up;
  logic [31:0] init_m;
  logic [31:0] src;
  logic [31:0] reg_v;

  always_comb begin
    wmask  = width_mask(cfg_i.width_mode);
    poly_n = cfg_i.polynomial & wmask;
    init_m = cfg_i.init_value & wmask;

    poly_rev = rev32(poly_n);
    up       = 1'b0;
    top_idx  = 5'd31;
    byte_sh  = 5'd24;
    emask    = 32'hFFFF_FFFF;
    case (cfg_i.width_mode)
      WM_7: begin
        poly_rev = rev32(poly_n) >> 25;
        up       = 1'b1;
        top_idx  = 5'd7;
        byte_sh  = 5'd0;
        emask    = 32'h0000_00FF;
      end
      WM_8: begin
        poly_rev = rev32(poly_n) >> 24;
        top_idx  = 5'd7;
        byte_sh  = 5'd0;
        emask    = 32'h0000_00FF;
      end
      WM_16: begin
        poly_rev = rev32(poly_n) >> 16;
        top_idx  = 5'd15;
        byte_sh  = 5'd8;
        emask    = 32'h0000_FFFF;
      end
      WM_32: begin
        poly_rev = rev32(poly_n);
      end
      default: ;
    endcase
    // 7-bit CRC runs left-aligned in an 8-bit register
    poly_msb = poly_n << up;

    if (cfg_i.reflected) begin
      src   = in_msg_i ? crc_i : init_m;
      reg_v = src ^ {24'd0, data_byte_i};
      for (int i = 0; i < 8; i++) begin
        reg_v = (reg_v >> 1) ^ (reg_v[0] ? poly_rev : 32'd0);
      end
      crc_next_o = reg_v & wmask;
      result_o   = (crc_next_o ^ cfg_i.xor_out) & wmask;
    end else begin
      src   = in_msg_i ? crc_i : (init_m << up);
      reg_v = src ^ ({24'd0, data_byte_i} << byte_sh);
      for (int i = 0; i < 8; i++) begin
        reg_v = (reg_v << 1) ^ (reg_v[top_idx] ? poly_msb : 32'd0);
      end
      crc_next_o = reg_v & emask;
      result_o   = ((crc_next_o >> up) ^ cfg_i.xor_out) & wmask;
    end
  end

endmodule

// ===== hdl/configurable_crc_engine_unit.sv =====
// Configurable byte-wise CRC engine (CRC-7, CRC-8, CRC-16, CRC-32): top level.
// Takes one message byte per cycle and keeps that rate indefinitely when the
// result side does not stall. A byte is registered on acceptance and then goes
// through the eight-step XOR-shift network into the CRC register. On a last
// byte the finished CRC enters the result register at that same edge. The
// combinational byte update through that network is what fixes the
// one-byte-per-cycle rate. Width, polynomial (normal form), init value, bit
// order and final XOR are set through the configuration port, which accepts a
// write every cycle; change them only between messages with no result pending.
module configurable_crc_engine_unit import ccrc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         data_byte_i,
  input  logic               last_byte_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [31:0]        crc_result_o
);

`include "configurable_crc_engine_unit_assert.svh"

  cfg_t        cfg;
  logic        a_valid_q;
  logic [7:0]  a_byte_q;
  logic        a_last_q;
  logic [31:0] crc_q;
  logic        in_msg_q;
  logic        o_valid_q;
  logic [31:0] o_crc_q;
  logic [31:0] crc_next;
  logic [31:0] result;
  logic        out_free;
  logic        a_fire;
  logic        in_take;

  assign cfg_ready_o = 1'b1;

  ccrc_regs u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i & cfg_ready_o),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  ccrc_core u_core (
    .cfg_i       (cfg),
    .crc_i       (crc_q),
    .in_msg_i    (in_msg_q),
    .data_byte_i (a_byte_q),
    .crc_next_o  (crc_next),
    .result_o    (result)
  );

  // a last word needs a free result slot; other words advance at once
  assign out_free   = !o_valid_q || !out_stall_i;
  assign a_fire     = a_valid_q && (!a_last_q || out_free);
  assign in_stall_o = a_valid_q && !a_fire;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (in_take) begin
      a_valid_q <= 1'b1;
    end else if (a_fire) begin
      a_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      a_byte_q <= data_byte_i;
      a_last_q <= last_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q    <= 32'd0;
      in_msg_q <= 1'b0;
    end else if (a_fire) begin
      crc_q    <= crc_next;
      in_msg_q <= !a_last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
    end else if (a_fire && a_last_q) begin
      o_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      o_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_fire && a_last_q) begin
      o_crc_q <= result;
    end
  end

  assign out_valid_o  = o_valid_q;
  assign crc_result_o = o_crc_q;

  `CCRC_ASSERT(a_last_ends_msg, a_fire && a_last_q |=> o_valid_q && !in_msg_q, "last word did not close the message")
  `CCRC_ASSERT(a_mid_keeps_msg, a_fire && !a_last_q |=> in_msg_q, "middle word did not keep the message open")
  `CCRC_ASSERT(stall_needs_busy, in_stall_o |-> a_valid_q && a_last_q && o_valid_q && out_stall_i, "input stalled without a blocked last word")
  `CCRC_ASSERT(result_in_width, o_valid_q |-> (o_crc_q & ~width_mask(cfg.width_mode)) == 32'd0, "result bits set above the CRC width")
  `CCRC_ASSERT_ALWAYS(reset_no_result, !rst_ni |-> !out_valid_o, "result valid during reset")

endmodule
